// ===== rtl/gtbg_pkg.sv =====
// Shared types and constants for the gesture tempo beat generator.
// No dependencies; every other file in rtl/ imports this package.
package gtbg_pkg;

  // Register map of the configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SLOW    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_MID     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_FAST    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_SLOW    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_MID     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FAST    = 4'd7;

  localparam int TICK_W = 16;
  localparam int TONE_W = 15;
  localparam int CFG_DATA_W = 16;

  // Reset values of the registers
  localparam logic [TICK_W-1:0] RST_LONG_PRESS   = 16'd2000;
  localparam logic [TICK_W-1:0] RST_DOUBLE_CLICK = 16'd400;
  localparam logic [TICK_W-1:0] RST_HALF_SLOW    = 16'd500;
  localparam logic [TICK_W-1:0] RST_HALF_MID     = 16'd250;
  localparam logic [TICK_W-1:0] RST_HALF_FAST    = 16'd125;
  localparam logic [TONE_W-1:0] RST_TONE_SLOW    = 15'd440;
  localparam logic [TONE_W-1:0] RST_TONE_MID     = 15'd880;
  localparam logic [TONE_W-1:0] RST_TONE_FAST    = 15'd1760;

  // Gesture codes; a gesture code also names the tempo level it selects
  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  localparam logic [1:0] LVL_STOP = 2'd0;
  localparam logic [1:0] LVL_SLOW = 2'd1;
  localparam logic [1:0] LVL_MID  = 2'd2;
  localparam logic [1:0] LVL_FAST = 2'd3;

  // Configuration register file contents
  typedef struct packed {
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] double_click_ticks;
    logic [TICK_W-1:0] half_period_slow;
    logic [TICK_W-1:0] half_period_mid;
    logic [TICK_W-1:0] half_period_fast;
    logic [TONE_W-1:0] tone_slow;
    logic [TONE_W-1:0] tone_mid;
    logic [TONE_W-1:0] tone_fast;
  } cfg_regs_t;

  // Gesture queue status seen by the top level and the back part
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/gtbg_front.sv =====
// Front part: edge detection, press and release timing, gesture classification.
// Depends on gtbg_pkg; pushes one gesture word per accepted tick into the queue.
module gtbg_front import gtbg_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic      button_level,
  input  cfg_regs_t cfg,
  output logic      push,
  output gesture_t  push_gesture
);

  localparam int CMPW = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   prev_level_r, prev_level_nxt;
  logic [COUNT_WIDTH-1:0] press_r, press_nxt;
  logic [COUNT_WIDTH-1:0] release_r, release_nxt;
  logic                   await_r, await_nxt;
  gesture_t               gesture;

  // Classify the tick and compute the next timer state
  always_comb begin
    logic fall;
    logic rise;
    fall        = prev_level_r & ~button_level;
    rise        = ~prev_level_r & button_level;
    press_nxt   = (press_r == CNT_MAX) ? press_r : press_r + 1'b1;
    release_nxt = (release_r == CNT_MAX) ? release_r : release_r + 1'b1;
    await_nxt   = await_r;
    gesture     = GEST_NONE;

    if (fall) begin
      press_nxt = '0;
    end else if (rise) begin
      priority if (CMPW'(press_nxt) >= CMPW'(cfg.long_press_ticks)) begin
        gesture   = GEST_LONG;
        await_nxt = 1'b0;
      end else if (await_r &&
                   CMPW'(release_nxt) <= CMPW'(cfg.double_click_ticks)) begin
        gesture   = GEST_DOUBLE;
        await_nxt = 1'b0;
      end else begin
        await_nxt   = 1'b1;
        release_nxt = '0;
      end
    end

    // Window ran out with no second release: report a single
    if (await_nxt && CMPW'(release_nxt) > CMPW'(cfg.double_click_ticks)) begin
      await_nxt = 1'b0;
      gesture   = GEST_SINGLE;
    end
  end

  assign prev_level_nxt = button_level;
  assign push           = accept;
  assign push_gesture   = gesture;

  // Advance timer state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      press_r      <= '0;
      release_r    <= '0;
      await_r      <= 1'b0;
    end else if (accept) begin
      prev_level_r <= prev_level_nxt;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
      await_r      <= await_nxt;
    end
  end

endmodule

// ===== rtl/gtbg_queue.sv =====
// Two-entry gesture queue between the front and back parts.
// Depends on gtbg_pkg; flop based, push and pop may happen in the same cycle.
module gtbg_queue import gtbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  gesture_t    push_gesture,
  input  logic        pop,
  output gesture_t    pop_gesture,
  output queue_stat_t stat
);

  gesture_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign stat.full   = (count_r == 2'd2);
  assign stat.empty  = (count_r == 2'd0);
  assign pop_gesture = mem_r[rd_ptr_r];

  // Move pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_gesture;
    end
  end

endmodule

// ===== rtl/gtbg_back.sv =====
// Back part: tempo level, beat phase timing and the registered result word.
// Depends on gtbg_pkg; pops one gesture word per result.
module gtbg_back import gtbg_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_regs_t         cfg,
  input  queue_stat_t       q_stat,
  input  gesture_t          q_gesture,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_light_on,
  output logic [TONE_W-1:0] out_tone_hz,
  output logic [1:0]        out_tempo_level,
  output logic [1:0]        out_gesture
);

  localparam int CMPW = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [1:0]             level_r, level_nxt;
  logic                   phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] beat_r, beat_nxt;
  logic                   valid_r, valid_nxt;
  logic                   light_r;
  logic [TONE_W-1:0]      tone_r, tone_nxt;
  logic [1:0]             level_out_r;
  logic [1:0]             gesture_r;
  logic                   advance;
  logic [TICK_W-1:0]      half;

  // Output register frees up when empty or being taken
  assign advance   = !valid_r || !out_stall;
  assign pop       = advance && !q_stat.empty;
  assign valid_nxt = advance ? !q_stat.empty : valid_r;

  // Apply the gesture, then run the beat timer
  always_comb begin
    beat_nxt  = (beat_r == CNT_MAX) ? beat_r : beat_r + 1'b1;
    level_nxt = level_r;
    phase_nxt = phase_r;
    if (q_gesture != GEST_NONE) begin
      level_nxt = q_gesture;
      phase_nxt = 1'b1;
      beat_nxt  = '0;
    end

    unique case (level_nxt)
      LVL_SLOW: half = cfg.half_period_slow;
      LVL_MID:  half = cfg.half_period_mid;
      default:  half = cfg.half_period_fast;
    endcase

    if (level_nxt != LVL_STOP && CMPW'(beat_nxt) >= CMPW'(half)) begin
      phase_nxt = ~phase_nxt;
      beat_nxt  = '0;
    end

    unique case (level_nxt)
      LVL_SLOW: tone_nxt = cfg.tone_slow;
      LVL_MID:  tone_nxt = cfg.tone_mid;
      LVL_FAST: tone_nxt = cfg.tone_fast;
      default:  tone_nxt = '0;
    endcase
    if (!phase_nxt) begin
      tone_nxt = '0;
    end
  end

  // Hold beat state; advance on each popped word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_STOP;
      phase_r <= 1'b0;
      beat_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        level_r <= level_nxt;
        phase_r <= phase_nxt;
        beat_r  <= beat_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      light_r     <= phase_nxt;
      tone_r      <= tone_nxt;
      level_out_r <= level_nxt;
      gesture_r   <= q_gesture;
    end
  end

  assign out_valid       = valid_r;
  assign out_light_on    = light_r;
  assign out_tone_hz     = tone_r;
  assign out_tempo_level = level_out_r;
  assign out_gesture     = gesture_r;

endmodule

// ===== rtl/gesture_tempo_beat_generator.sv =====
// Top level of the gesture tempo beat generator: configuration registers,
// front part, gesture queue and back part. Depends on gtbg_pkg.
//
//   channel  ports                                      handshake
//   -------  -----------------------------------------  ---------------
//   in       in_button_level                            in_valid/in_stall
//   out      out_light_on, out_tone_hz,                 out_valid/out_stall
//            out_tempo_level, out_gesture
//   cfg      cfg_index, cfg_data                        cfg_valid/cfg_ready
//
// One word in, one word out. A tick word is taken every cycle unless in_stall is
// high; its gesture is written into the queue on the accepting edge, and the back
// part moves it into the output register when that register is free.
// The two-entry queue absorbs output stalls, so in_stall rises only when the
// queue is full and the back part cannot drain it this cycle.
// Synchronous active-low reset; cfg_ready is always high.
module gesture_tempo_beat_generator import gtbg_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_button_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_light_on,
  output logic [TONE_W-1:0]     out_tone_hz,
  output logic [1:0]            out_tempo_level,
  output logic [1:0]            out_gesture,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t   cfg_r;
  logic        accept;
  logic        push;
  gesture_t    push_gesture;
  logic        pop;
  gesture_t    q_gesture;
  queue_stat_t q_stat;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks   <= RST_LONG_PRESS;
      cfg_r.double_click_ticks <= RST_DOUBLE_CLICK;
      cfg_r.half_period_slow   <= RST_HALF_SLOW;
      cfg_r.half_period_mid    <= RST_HALF_MID;
      cfg_r.half_period_fast   <= RST_HALF_FAST;
      cfg_r.tone_slow          <= RST_TONE_SLOW;
      cfg_r.tone_mid           <= RST_TONE_MID;
      cfg_r.tone_fast          <= RST_TONE_FAST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS:   cfg_r.long_press_ticks   <= cfg_data;
        REG_DOUBLE_CLICK: cfg_r.double_click_ticks <= cfg_data;
        REG_HALF_SLOW:    cfg_r.half_period_slow   <= cfg_data;
        REG_HALF_MID:     cfg_r.half_period_mid    <= cfg_data;
        REG_HALF_FAST:    cfg_r.half_period_fast   <= cfg_data;
        REG_TONE_SLOW:    cfg_r.tone_slow          <= cfg_data[TONE_W-1:0];
        REG_TONE_MID:     cfg_r.tone_mid           <= cfg_data[TONE_W-1:0];
        REG_TONE_FAST:    cfg_r.tone_fast          <= cfg_data[TONE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Stall input only when the queue cannot take a word this cycle
  assign in_stall = q_stat.full && !pop;
  assign accept   = in_valid && !in_stall;

  gtbg_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .button_level (in_button_level),
    .cfg          (cfg_r),
    .push         (push),
    .push_gesture (push_gesture)
  );

  gtbg_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .push_gesture (push_gesture),
    .pop          (pop),
    .pop_gesture  (q_gesture),
    .stat         (q_stat)
  );

  gtbg_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_stat          (q_stat),
    .q_gesture       (q_gesture),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_light_on    (out_light_on),
    .out_tone_hz     (out_tone_hz),
    .out_tempo_level (out_tempo_level),
    .out_gesture     (out_gesture)
  );

endmodule
